// File: hw/rtl/ulrr_pkg.sv
// Shared types and constants for the line record ring.
// No dependencies; uart_line_record_ring refers to it by scoped names.
package ulrr_pkg;

    // Line terminator characters.
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // Sequencer states, one-hot coded.
    typedef enum logic [10:0] {
        S_INIT   = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_RDSUCC = 11'b000_0000_0100,
        S_MOD    = 11'b000_0000_1000,
        S_CLEAR  = 11'b000_0001_0000,
        S_WRITE  = 11'b000_0010_0000,
        S_EVAL   = 11'b000_0100_0000,
        S_LINK   = 11'b000_1000_0000,
        S_SETH   = 11'b001_0000_0000,
        S_SETW   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    // One result transaction.
    typedef struct packed {
        logic       line_done;
        logic [7:0] line_header;
        logic [7:0] new_header;
        logic       empty_dropped;
        logic       oldest_dropped;
        logic       single_wrapped;
        logic [7:0] oldest_index;
        logic [7:0] write_index;
    } t_result;

endpackage

// File: hw/rtl/ulrr_if.sv
// Channel interfaces of the line record ring: received bytes in, results out.
// No dependencies.
interface ulrr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ulrr_out_if;
    logic       valid;
    logic       ready;
    logic       line_done;
    logic [7:0] line_header;
    logic [7:0] new_header;
    logic       empty_dropped;
    logic       oldest_dropped;
    logic       single_wrapped;
    logic [7:0] oldest_index;
    logic [7:0] write_index;

    modport source (
        output valid, output line_done, output line_header, output new_header,
        output empty_dropped, output oldest_dropped, output single_wrapped,
        output oldest_index, output write_index, input ready
    );
    modport sink (
        input valid, input line_done, input line_header, input new_header,
        input empty_dropped, input oldest_dropped, input single_wrapped,
        input oldest_index, input write_index, output ready
    );
endinterface

// File: hw/rtl/uart_line_record_ring.sv
// Top level of the line record ring: sequencer, pointers and result register.
// Depends on ulrr_pkg, ulrr_if (ulrr_in_if, ulrr_out_if) and ulrr_store.
//
//   Channel   Direction  Payload                                    Handshake
//   i_in      sink       rx_byte                                    valid/ready
//   o_out     source     line_done, line_header, new_header,        valid/ready
//                        empty_dropped, oldest_dropped,
//                        single_wrapped, oldest_index, write_index
//
// Each accepted byte passes through S_WRITE, S_EVAL and S_DONE; a byte that
// closes a line also passes through S_LINK, S_SETH and S_SETW. When the write
// slot reaches the oldest header, S_RDSUCC and the successor reduction steps
// in S_MOD come first; dropping the oldest record adds S_CLEAR, which clears
// one slot per step; the single store write port sets this sequence.
// After reset a clearing pass loads every slot with its own index; no byte is
// taken meanwhile. A stalled result waits in the output register and holds
// the sequencer in its final state.
module uart_line_record_ring #(
    parameter int STORE_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ulrr_in_if.sink        i_in,
    ulrr_out_if.source     o_out
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int EW = (IW > 8) ? IW : 8;
    localparam logic [IW-1:0] LAST_IDX = IW'(STORE_DEPTH - 1);
    localparam logic [IW:0]   DEPTH_I  = (IW + 1)'(STORE_DEPTH);
    localparam logic [EW:0]   DEPTH_E  = (EW + 1)'(STORE_DEPTH);

    // Wrapping index helpers.
    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] x);
        logic [IW-1:0] y;
        y = (x == LAST_IDX) ? '0 : x + 1'b1;
        return y;
    endfunction

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] x);
        logic [IW-1:0] y;
        y = (x == '0) ? LAST_IDX : x - 1'b1;
        return y;
    endfunction

    function automatic logic [IW-1:0] f_add3(input logic [IW-1:0] x);
        logic [IW:0] s;
        s = {1'b0, x} + (IW + 1)'(3);
        if (s >= DEPTH_I) begin
            s = s - DEPTH_I;
        end
        return s[IW-1:0];
    endfunction

    ulrr_pkg::t_state  r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_old, n_old;
    logic [IW-1:0]     r_last, n_last;
    logic [IW-1:0]     r_wp, n_wp;
    logic [IW-1:0]     r_p2, n_p2;
    logic [IW-1:0]     r_p1, n_p1;
    logic [EW-1:0]     r_succ, n_succ;
    logic [7:0]        r_byte, n_byte;
    ulrr_pkg::t_result r_work, n_work;
    ulrr_pkg::t_result r_res, n_res;
    logic              r_ovalid, n_ovalid;

    logic              s_we;
    logic [IW-1:0]     s_waddr;
    logic [EW-1:0]     s_wdata;
    logic [IW-1:0]     s_raddr;
    logic [EW-1:0]     s_rdata;
    logic              s_accept;
    logic              s_out_free;

    ulrr_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (IW),
        .DW    (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign i_in.ready = (r_state == ulrr_pkg::S_IDLE);
    assign s_accept   = i_in.valid && (r_state == ulrr_pkg::S_IDLE);
    assign s_out_free = !r_ovalid || o_out.ready;

    // Sequencer: pointer updates, store accesses and result assembly.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_old    = r_old;
        n_last   = r_last;
        n_wp     = r_wp;
        n_p2     = r_p2;
        n_p1     = r_p1;
        n_succ   = r_succ;
        n_byte   = r_byte;
        n_work   = r_work;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        s_we     = 1'b0;
        s_waddr  = r_idx;
        s_wdata  = EW'(r_idx);
        s_raddr  = r_old;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            // Clearing pass: every slot gets its own index.
            ulrr_pkg::S_INIT: begin
                s_we    = 1'b1;
                s_waddr = r_idx;
                s_wdata = EW'(r_idx);
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ulrr_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // Wait for a byte; the oldest header is read ahead.
            ulrr_pkg::S_IDLE: begin
                s_raddr = r_old;
                if (s_accept) begin
                    n_byte = i_in.rx_byte;
                    n_work = '0;
                    if (r_wp == r_old) begin
                        n_state = ulrr_pkg::S_RDSUCC;
                    end else begin
                        n_state = ulrr_pkg::S_WRITE;
                    end
                end
            end
            // Latch the successor header of the oldest record.
            ulrr_pkg::S_RDSUCC: begin
                n_succ  = s_rdata;
                n_state = ulrr_pkg::S_MOD;
            end
            // Reduce the successor into the index range, then drop or advance.
            ulrr_pkg::S_MOD: begin
                if ({1'b0, r_succ} >= DEPTH_E) begin
                    n_succ = EW'({1'b0, r_succ} - DEPTH_E);
                end else if (r_succ[IW-1:0] == r_old) begin
                    s_we    = 1'b1;
                    s_waddr = f_inc(r_last);
                    s_wdata = EW'(f_inc(r_last));
                    n_last  = f_inc(r_last);
                    n_old   = f_inc(r_last);
                    n_work.single_wrapped = 1'b1;
                    n_state = ulrr_pkg::S_WRITE;
                end else begin
                    n_idx   = r_old;
                    n_state = ulrr_pkg::S_CLEAR;
                end
            end
            // Clear the slots of the dropped record up to its successor.
            ulrr_pkg::S_CLEAR: begin
                if (r_idx != r_succ[IW-1:0]) begin
                    s_we    = 1'b1;
                    s_waddr = r_idx;
                    s_wdata = EW'(r_idx);
                    n_idx   = f_inc(r_idx);
                end else begin
                    n_old   = r_succ[IW-1:0];
                    n_work.oldest_dropped = 1'b1;
                    n_state = ulrr_pkg::S_WRITE;
                end
            end
            // Store the byte and read the slot before it.
            ulrr_pkg::S_WRITE: begin
                s_we    = 1'b1;
                s_waddr = r_wp;
                s_wdata = EW'(r_byte);
                s_raddr = f_dec(r_wp);
                n_p2    = f_dec(r_wp);
                n_p1    = r_wp;
                n_wp    = f_inc(r_wp);
                n_state = ulrr_pkg::S_EVAL;
            end
            // CR LF test on the two slots before the write position.
            ulrr_pkg::S_EVAL: begin
                if ((s_rdata == EW'(ulrr_pkg::CHAR_CR)) && (r_byte == ulrr_pkg::CHAR_LF)) begin
                    if (r_wp == f_add3(r_last)) begin
                        n_wp    = r_p2;
                        n_work.empty_dropped = 1'b1;
                        n_state = ulrr_pkg::S_DONE;
                    end else begin
                        n_state = ulrr_pkg::S_LINK;
                    end
                end else begin
                    n_state = ulrr_pkg::S_DONE;
                end
            end
            // Point the closed header at the new one.
            ulrr_pkg::S_LINK: begin
                s_we    = 1'b1;
                s_waddr = r_last;
                s_wdata = EW'(r_p2);
                n_work.line_header = 8'(r_last);
                n_last  = r_p2;
                n_state = ulrr_pkg::S_SETH;
            end
            // The new header is the last record and points at itself.
            ulrr_pkg::S_SETH: begin
                s_we    = 1'b1;
                s_waddr = r_last;
                s_wdata = EW'(r_last);
                n_state = ulrr_pkg::S_SETW;
            end
            // Clear the LF slot, which becomes the next write slot.
            ulrr_pkg::S_SETW: begin
                s_we    = 1'b1;
                s_waddr = r_p1;
                s_wdata = EW'(r_p1);
                n_wp    = r_p1;
                n_work.new_header = 8'(r_last);
                n_work.line_done  = 1'b1;
                n_state = ulrr_pkg::S_DONE;
            end
            // Hand the result to the output register once it is free.
            ulrr_pkg::S_DONE: begin
                if (s_out_free) begin
                    n_res              = r_work;
                    n_res.oldest_index = 8'(r_old);
                    n_res.write_index  = 8'(r_wp);
                    n_ovalid           = 1'b1;
                    n_state            = ulrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ulrr_pkg::S_INIT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ulrr_pkg::S_INIT;
            r_idx    <= '0;
            r_old    <= '0;
            r_last   <= '0;
            r_wp     <= IW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_old    <= n_old;
            r_last   <= n_last;
            r_wp     <= n_wp;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_p2   <= n_p2;
        r_p1   <= n_p1;
        r_succ <= n_succ;
        r_byte <= n_byte;
        r_work <= n_work;
        r_res  <= n_res;
    end

    // Result channel.
    assign o_out.valid          = r_ovalid;
    assign o_out.line_done      = r_res.line_done;
    assign o_out.line_header    = r_res.line_header;
    assign o_out.new_header     = r_res.new_header;
    assign o_out.empty_dropped  = r_res.empty_dropped;
    assign o_out.oldest_dropped = r_res.oldest_dropped;
    assign o_out.single_wrapped = r_res.single_wrapped;
    assign o_out.oldest_index   = r_res.oldest_index;
    assign o_out.write_index    = r_res.write_index;

endmodule

// File: hw/rtl/ulrr_store.sv
// Record store of the line record ring: one write port, one registered read port.
// No dependencies; instantiated by uart_line_record_ring.
module ulrr_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Synchronous write and registered read; a read of the address being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
